>>> rtl/zpba_pkg.sv
// ----------------------------------------------------------------------------
// zpba_pkg
// Shared types, constants and table functions of the zone proximity alert.
// ----------------------------------------------------------------------------
package zpba_pkg;

  // Zones in one frame; the frame average divides the frame sum by this
  localparam int ZONE_COUNT = 16;

  // Field widths
  localparam int LIMIT_W = 10;
  localparam int MM_W    = 13;
  localparam int CM_W    = 10;
  localparam int SUM_W   = 16;
  localparam int TIME_W  = 32;
  localparam int FREQ_W  = 12;
  localparam int COUNT_W = 16;
  localparam int LEVEL_W = 3;
  localparam int TICK_W  = 8;

  // Divide by ten: multiply by the reciprocal 52429 / 2^19, exact below 43690
  localparam int DIV10_MUL    = 52429;
  localparam int DIV10_MUL_W  = 16;
  localparam int DIV10_SHIFT  = 19;
  localparam int DIV10_PROD_W = MM_W + DIV10_MUL_W;

  // Configuration register indexes
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_IMMEDIATE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CLOSE     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MEDIUM    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MEDIUMFAR = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FAR       = 3'd4;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [LEVEL_W-1:0] {
    LVL_SILENT    = 3'd0,
    LVL_FAR       = 3'd1,
    LVL_MEDIUMFAR = 3'd2,
    LVL_MEDIUM    = 3'd3,
    LVL_CLOSE     = 3'd4,
    LVL_IMMEDIATE = 3'd5
  } level_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] immediate_cm;
    logic [LIMIT_W-1:0] close_cm;
    logic [LIMIT_W-1:0] medium_cm;
    logic [LIMIT_W-1:0] mediumfar_cm;
    logic [LIMIT_W-1:0] far_cm;
  } limits_t;

  typedef struct packed {
    level_t              zone_level;
    logic                frame_last;
    logic [SUM_W-1:0]    avg_cm;
    logic [TIME_W-1:0]   time_ms;
  } qentry_t;

  // Sort a distance in cm into a level, nearest limit first
  function automatic level_t classify(input logic [SUM_W-1:0] cm, input limits_t lim);
    level_t lvl;
    if (cm <= SUM_W'(lim.immediate_cm)) lvl = LVL_IMMEDIATE;
    else if (cm <= SUM_W'(lim.close_cm)) lvl = LVL_CLOSE;
    else if (cm <= SUM_W'(lim.medium_cm)) lvl = LVL_MEDIUM;
    else if (cm <= SUM_W'(lim.mediumfar_cm)) lvl = LVL_MEDIUMFAR;
    else if (cm <= SUM_W'(lim.far_cm)) lvl = LVL_FAR;
    else lvl = LVL_SILENT;
    return lvl;
  endfunction

  function automatic logic [FREQ_W-1:0] tone_freq(input level_t lvl);
    logic [FREQ_W-1:0] f;
    case (lvl)
      LVL_FAR:       f = 12'd800;
      LVL_MEDIUMFAR: f = 12'd1000;
      LVL_MEDIUM:    f = 12'd1200;
      LVL_CLOSE:     f = 12'd1800;
      LVL_IMMEDIATE: f = 12'd2500;
      default:       f = 12'd0;
    endcase
    return f;
  endfunction

  // Beep length in ms
  function automatic logic [TICK_W-1:0] beep_dur(input level_t lvl);
    logic [TICK_W-1:0] d;
    case (lvl)
      LVL_FAR, LVL_MEDIUMFAR, LVL_MEDIUM, LVL_CLOSE: d = 8'd50;
      LVL_IMMEDIATE: d = 8'd70;
      default:       d = 8'd0;
    endcase
    return d;
  endfunction

  // Gap between beeps in ms
  function automatic logic [TICK_W-1:0] beep_gap(input level_t lvl);
    logic [TICK_W-1:0] g;
    case (lvl)
      LVL_FAR, LVL_MEDIUMFAR: g = 8'd50;
      LVL_MEDIUM:    g = 8'd80;
      LVL_CLOSE:     g = 8'd120;
      LVL_IMMEDIATE: g = 8'd200;
      default:       g = 8'd0;
    endcase
    return g;
  endfunction

endpackage

>>> rtl/zpba_in_if.sv
// ----------------------------------------------------------------------------
// zpba_in_if
// Zone sample channel: valid/ready with distance, frame marker and time.
// ----------------------------------------------------------------------------
interface zpba_in_if;
  logic                        valid;
  logic                        ready;
  logic [zpba_pkg::MM_W-1:0]   zone_mm;
  logic                        frame_last;
  logic [zpba_pkg::TIME_W-1:0] time_ms;

  modport source (output valid, output zone_mm, output frame_last, output time_ms,
                  input ready);
  modport sink (input valid, input zone_mm, input frame_last, input time_ms,
                output ready);
endinterface

>>> rtl/zpba_out_if.sv
// ----------------------------------------------------------------------------
// zpba_out_if
// Alert result channel: valid/ready with zone level and beeper status.
// ----------------------------------------------------------------------------
interface zpba_out_if;
  logic                         valid;
  logic                         ready;
  logic [zpba_pkg::LEVEL_W-1:0] zone_level;
  logic                         frame_done;
  logic [zpba_pkg::LEVEL_W-1:0] frame_level;
  logic                         beep_on;
  logic [zpba_pkg::FREQ_W-1:0]  tone_freq_hz;
  logic [zpba_pkg::COUNT_W-1:0] beep_total;

  modport source (output valid, output zone_level, output frame_done,
                  output frame_level, output beep_on, output tone_freq_hz,
                  output beep_total, input ready);
  modport sink (input valid, input zone_level, input frame_done,
                input frame_level, input beep_on, input tone_freq_hz,
                input beep_total, output ready);
endinterface

>>> rtl/zpba_front.sv
// ----------------------------------------------------------------------------
// zpba_front
// Accept zone samples, convert to cm, classify and keep the frame sum.
// ----------------------------------------------------------------------------
module zpba_front (
  input  logic              clk,
  input  logic              rst,
  zpba_in_if.sink           zone_in,
  input  zpba_pkg::limits_t limits,
  input  logic              q_full,
  output logic              push,
  output zpba_pkg::qentry_t push_data
);

  logic [zpba_pkg::DIV10_PROD_W-1:0] cm_prod;
  logic [zpba_pkg::CM_W-1:0]         cm;
  logic [zpba_pkg::SUM_W:0]          sum_wide;
  logic [zpba_pkg::SUM_W-1:0]        sum_sat;
  logic [zpba_pkg::SUM_W-1:0]        avg_cm;
  logic [zpba_pkg::SUM_W-1:0]        frame_sum;
  logic [zpba_pkg::SUM_W-1:0]        frame_sum_next;

  // Accept whenever the queue has room
  assign zone_in.ready = !q_full;
  assign push          = zone_in.valid && !q_full;

  // Millimetres to whole centimetres by reciprocal multiply
  assign cm_prod = zpba_pkg::DIV10_PROD_W'(zone_in.zone_mm)
                 * zpba_pkg::DIV10_PROD_W'(zpba_pkg::DIV10_MUL);
  assign cm      = cm_prod[zpba_pkg::DIV10_SHIFT +: zpba_pkg::CM_W];

  // Saturating frame sum including this zone
  assign sum_wide = {1'b0, frame_sum} + (zpba_pkg::SUM_W + 1)'(cm);
  assign sum_sat  = sum_wide[zpba_pkg::SUM_W] ? '1 : sum_wide[zpba_pkg::SUM_W-1:0];

  // Frame average (zone count is a power of two, so this is a shift)
  assign avg_cm = zpba_pkg::SUM_W'(sum_sat / zpba_pkg::SUM_W'(zpba_pkg::ZONE_COUNT));

  // Build the queue entry
  always_comb begin
    push_data.zone_level = zpba_pkg::classify(zpba_pkg::SUM_W'(cm), limits);
    push_data.frame_last = zone_in.frame_last;
    push_data.avg_cm     = zone_in.frame_last ? avg_cm : '0;
    push_data.time_ms    = zone_in.time_ms;
  end

  // Advance the frame sum; clear it at the frame end
  always_comb begin
    frame_sum_next = frame_sum;
    if (push) begin
      frame_sum_next = zone_in.frame_last ? '0 : sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_sum <= '0;
    end else begin
      frame_sum <= frame_sum_next;
    end
  end

endmodule

>>> rtl/zpba_queue.sv
// ----------------------------------------------------------------------------
// zpba_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module zpba_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  zpba_pkg::qentry_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              q_valid,
  output zpba_pkg::qentry_t q_data
);

  localparam logic [zpba_pkg::QPTR_W-1:0] PTR_LAST = zpba_pkg::QPTR_W'(zpba_pkg::QUEUE_DEPTH - 1);
  localparam logic [zpba_pkg::QCNT_W-1:0] CNT_FULL = zpba_pkg::QCNT_W'(zpba_pkg::QUEUE_DEPTH);

  zpba_pkg::qentry_t               entries [zpba_pkg::QUEUE_DEPTH];
  logic [zpba_pkg::QPTR_W-1:0]     wr_ptr;
  logic [zpba_pkg::QPTR_W-1:0]     wr_ptr_next;
  logic [zpba_pkg::QPTR_W-1:0]     rd_ptr;
  logic [zpba_pkg::QPTR_W-1:0]     rd_ptr_next;
  logic [zpba_pkg::QCNT_W-1:0]     count;
  logic [zpba_pkg::QCNT_W-1:0]     count_next;

  assign full    = (count == CNT_FULL);
  assign q_valid = (count != '0);
  assign q_data  = entries[rd_ptr];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (push) begin
      wr_ptr_next = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("queue pushed while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !q_valid |-> !pop)
    else $error("queue popped while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("queue occupancy out of range");
`endif

endmodule

>>> rtl/zpba_back.sv
// ----------------------------------------------------------------------------
// zpba_back
// Classify the frame average, run the beeper and hold the result register.
// ----------------------------------------------------------------------------
module zpba_back (
  input  logic              clk,
  input  logic              rst,
  input  zpba_pkg::limits_t limits,
  input  logic              q_valid,
  input  zpba_pkg::qentry_t q_data,
  output logic              pop,
  zpba_out_if.source        alert_out
);

  zpba_pkg::level_t                active_level;
  zpba_pkg::level_t                active_level_next;
  logic                            beeping;
  logic                            beeping_next;
  logic [zpba_pkg::TIME_W-1:0]     beep_start_ms;
  logic [zpba_pkg::TIME_W-1:0]     beep_start_ms_next;
  logic [zpba_pkg::TIME_W-1:0]     beep_end_ms;
  logic [zpba_pkg::TIME_W-1:0]     beep_end_ms_next;
  logic [zpba_pkg::COUNT_W-1:0]    beep_counter;
  logic [zpba_pkg::COUNT_W-1:0]    beep_counter_next;

  zpba_pkg::level_t                avg_level;
  logic                            frame_evt;
  logic                            level_change;
  zpba_pkg::level_t                target_level;
  logic [zpba_pkg::TIME_W-1:0]     end_base;
  logic [zpba_pkg::TIME_W-1:0]     since_start;
  logic [zpba_pkg::TIME_W-1:0]     since_end;
  logic                            dur_done;
  logic                            gap_done;

  logic                            out_valid;
  logic                            out_valid_next;
  logic [zpba_pkg::LEVEL_W-1:0]    out_zone_level;
  logic                            out_frame_done;
  logic [zpba_pkg::LEVEL_W-1:0]    out_frame_level;
  logic                            out_beep_on;
  logic [zpba_pkg::FREQ_W-1:0]     out_tone_freq_hz;
  logic [zpba_pkg::COUNT_W-1:0]    out_beep_total;

  // Take the next item when the result register is free or draining
  assign pop = q_valid && (!out_valid || alert_out.ready);

  assign avg_level    = zpba_pkg::classify(q_data.avg_cm, limits);
  assign frame_evt    = pop && q_data.frame_last;
  assign level_change = (avg_level != active_level);
  assign target_level = level_change ? avg_level : active_level;
  assign end_base     = level_change ? '0 : beep_end_ms;

  // Modular elapsed times against the level's duration and gap
  assign since_start = q_data.time_ms - beep_start_ms;
  assign since_end   = q_data.time_ms - end_base;
  assign dur_done    = since_start >= zpba_pkg::TIME_W'(zpba_pkg::beep_dur(target_level));
  assign gap_done    = since_end >= zpba_pkg::TIME_W'(zpba_pkg::beep_gap(target_level));

  // Beeper update on a frame end
  always_comb begin
    active_level_next  = active_level;
    beeping_next       = beeping;
    beep_start_ms_next = beep_start_ms;
    beep_end_ms_next   = beep_end_ms;
    beep_counter_next  = beep_counter;
    if (frame_evt) begin
      active_level_next = target_level;
      beep_end_ms_next  = end_base;
      if (target_level == zpba_pkg::LVL_SILENT) begin
        beeping_next = 1'b0;
      end else if (beeping && !level_change) begin
        if (dur_done) begin
          beeping_next      = 1'b0;
          beep_end_ms_next  = q_data.time_ms;
          beep_counter_next = beep_counter + 1'b1;
        end
      end else begin
        beeping_next = gap_done;
        if (gap_done) begin
          beep_start_ms_next = q_data.time_ms;
        end
      end
    end
  end

  // Hold the result until it is taken
  always_comb begin
    out_valid_next = out_valid;
    if (pop) begin
      out_valid_next = 1'b1;
    end else if (alert_out.ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_level  <= zpba_pkg::LVL_SILENT;
      beeping       <= 1'b0;
      beep_start_ms <= '0;
      beep_end_ms   <= '0;
      beep_counter  <= '0;
      out_valid     <= 1'b0;
    end else begin
      active_level  <= active_level_next;
      beeping       <= beeping_next;
      beep_start_ms <= beep_start_ms_next;
      beep_end_ms   <= beep_end_ms_next;
      beep_counter  <= beep_counter_next;
      out_valid     <= out_valid_next;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      out_zone_level   <= q_data.zone_level;
      out_frame_done   <= q_data.frame_last;
      out_frame_level  <= q_data.frame_last ? avg_level : zpba_pkg::LVL_SILENT;
      out_beep_on      <= beeping_next;
      out_tone_freq_hz <= zpba_pkg::tone_freq(active_level_next);
      out_beep_total   <= beep_counter_next;
    end
  end

  assign alert_out.valid        = out_valid;
  assign alert_out.zone_level   = out_zone_level;
  assign alert_out.frame_done   = out_frame_done;
  assign alert_out.frame_level  = out_frame_level;
  assign alert_out.beep_on      = out_beep_on;
  assign alert_out.tone_freq_hz = out_tone_freq_hz;
  assign alert_out.beep_total   = out_beep_total;

`ifndef SYNTHESIS
  a_avg_only_on_frame: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_frame_done) |-> (out_frame_level == zpba_pkg::LVL_SILENT))
    else $error("average level reported outside a frame end");
  a_count_on_beep_end: assert property (@(posedge clk) disable iff (rst)
    (beep_counter_next != beep_counter) |-> (beeping && !beeping_next))
    else $error("beep counted without a beep ending");
  a_silent_quiet: assert property (@(posedge clk) disable iff (rst)
    (active_level == zpba_pkg::LVL_SILENT) |-> !beeping)
    else $error("beeping while silent");
`endif

endmodule

>>> rtl/zone_proximity_beep_alert.sv
// ----------------------------------------------------------------------------
// zone_proximity_beep_alert
// Zone distance classifier with frame averaging and a level-driven beeper.
// ----------------------------------------------------------------------------
// Takes one zone sample per clock and returns one result per sample, in
// order. The front converts and classifies an accepted sample and pushes
// it into a two-entry queue; the back pops it through the beeper and into
// the result register. Throughput is one item per cycle as long as results
// are taken; a stalled output fills the result register and the queue,
// then input ready drops. Limit registers are to be written through the
// write port only while no item is in flight; the block does not enforce
// this. There is no clearing pass after reset.
module zone_proximity_beep_alert (
  input  logic                             clk,
  input  logic                             rst,
  zpba_in_if.sink                          zone_in,
  zpba_out_if.source                       alert_out,
  input  logic                             cfg_wr_en,
  input  logic [zpba_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [zpba_pkg::LIMIT_W-1:0]     cfg_data
);

  zpba_pkg::limits_t limits;
  logic              push;
  zpba_pkg::qentry_t push_data;
  logic              q_full;
  logic              pop;
  logic              q_valid;
  zpba_pkg::qentry_t q_data;

  // Limit registers; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      limits.immediate_cm <= 10'd40;
      limits.close_cm     <= 10'd80;
      limits.medium_cm    <= 10'd100;
      limits.mediumfar_cm <= 10'd150;
      limits.far_cm       <= 10'd200;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        zpba_pkg::REG_IMMEDIATE: limits.immediate_cm <= cfg_data;
        zpba_pkg::REG_CLOSE:     limits.close_cm     <= cfg_data;
        zpba_pkg::REG_MEDIUM:    limits.medium_cm    <= cfg_data;
        zpba_pkg::REG_MEDIUMFAR: limits.mediumfar_cm <= cfg_data;
        zpba_pkg::REG_FAR:       limits.far_cm       <= cfg_data;
        default: ;
      endcase
    end
  end

  zpba_front u_front (
    .clk       (clk),
    .rst       (rst),
    .zone_in   (zone_in),
    .limits    (limits),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  zpba_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  zpba_back u_back (
    .clk       (clk),
    .rst       (rst),
    .limits    (limits),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .alert_out (alert_out)
  );

endmodule
